>>> hw/rtl/tbct_pkg.sv
// ----------------------------------------------------------------------------
// tbct_pkg: beacon clock tracker shared types and constants
// Payload structs, register indexes and widths used by the tracker modules.
// ----------------------------------------------------------------------------
package tbct_pkg;

   localparam int unsigned FRAME_SLOT_COUNT = 10;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 24;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BEACON_INTERVAL = 3'd0,
      CSR_PHASE_GAIN      = 3'd1,
      CSR_FREQUENCY_GAIN  = 3'd2,
      CSR_SLOT_LENGTH     = 3'd3,
      CSR_OWN_NODE_ID     = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_BEACON = 1'b0,
      OP_SLOT   = 1'b1
   } op_type;

   typedef struct packed {
      logic        op;
      logic [31:0] beacon_time;
      logic [31:0] beacon_number;
      logic [15:0] slot_owner;
      logic        slot_is_uplink;
   } req_type;

   typedef struct packed {
      logic        report_kind;
      logic [31:0] local_estimate;
      logic signed [31:0] timing_error;
      logic signed [31:0] frequency_estimate;
      logic        transmit_grant;
      logic [31:0] transmit_time;
   } rsp_type;

endpackage

>>> hw/rtl/tdma_beacon_clock_tracker.sv
// ----------------------------------------------------------------------------
// tdma_beacon_clock_tracker: second-order beacon timing loop
// Tracks the beacon clock and grants uplink slot transmit times.
// ----------------------------------------------------------------------------
// Slot transaction: one serial multiply between accept and rsp_valid.
// Beacon transaction: five serial multiplies and one serial divide run back
// to back on one shared sequencer.
// One transaction at a time; req stalls until the result is taken.
// Reset (synchronous): returns to idle, clears the loop state to zero and loads register defaults.
module tdma_beacon_clock_tracker
   import tbct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_STEP1  = 9'b000000010,
      ST_MISS   = 9'b000000100,
      ST_PHASE  = 9'b000001000,
      ST_FGAIN  = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_STEP2  = 9'b001000000,
      ST_SLOT   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [23:0] interval_ff;
   logic [15:0] pgain_ff, fgain_ff, node_ff;
   logic [19:0] slen_ff;
   logic [31:0] ltime_ff, ltime_in, foff_ff, foff_in, prev_ff, prev_in;
   logic [31:0] base_ff, base_in;
   logic [3:0]  sidx_ff, sidx_in;
   req_type     req_ff, req_in;
   logic [31:0] missed_ff, missed_in, err_ff, err_in;
   logic [31:0] step_ff, step_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rvalid_ff, rvalid_in;
   logic [63:0] fg_ff, fg_in;

   logic        mul_start, mul_busy, div_start, div_busy;
   logic signed [63:0] m_a, m_prod, d_q;
   logic [31:0] m_b;

   tbct_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .mcand(m_a),
      .mplier(m_b), .busy(mul_busy), .product(m_prod)
   );
   tbct_serial_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(fg_ff),
      .divisor(interval_ff), .busy(div_busy), .quotient(d_q)
   );

   logic        launched_ff, launched_in;
   logic        accept;
   logic signed [63:0] step_full, fnew;
   logic [31:0] perr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rvalid_ff;
   // step = floor((interval*(2^30+f) + 2^29) / 2^30)
   assign step_full = (m_prod + 64'sd536870912) >>> 30;
   assign perr      = 32'((m_prod + 64'sd32768) >>> 16);
   assign fnew      = $signed({{32{foff_ff[31]}}, foff_ff}) + d_q;

   always_comb begin
      state_in = state_ff; ltime_in = ltime_ff; foff_in = foff_ff;
      prev_in = prev_ff; base_in = base_ff; sidx_in = sidx_ff; req_in = req_ff;
      missed_in = missed_ff; err_in = err_ff; step_in = step_ff;
      rsp_in = rsp_ff; rvalid_in = rvalid_ff;
      fg_in = fg_ff; launched_in = 1'b0;
      mul_start = 1'b0; div_start = 1'b0;
      m_a = '0; m_b = '0;
      if (rvalid_ff && !rsp_stall) rvalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               rsp_in = '0;
               if (req_data.op == OP_BEACON) begin
                  state_in = ST_STEP1;
                  missed_in = (req_data.beacon_number > prev_ff) ?
                     req_data.beacon_number - prev_ff - 32'd1 : 32'd0;
                  prev_in = req_data.beacon_number;
               end else begin
                  state_in = ST_SLOT;
                  rsp_in.report_kind = 1'b1;
               end
               launched_in = 1'b1;
            end
         end
         ST_STEP1, ST_STEP2: begin
            m_a = $signed({{32{foff_ff[31]}}, foff_ff}) + 64'sd1073741824;
            m_b = {8'd0, interval_ff};
            mul_start = launched_ff;
            if (!launched_ff && !mul_busy) begin
               step_in = 32'(step_full);
               if (state_ff == ST_STEP1) begin
                  state_in = ST_MISS;
               end else begin
                  ltime_in = ltime_ff + 32'(step_full);
                  state_in = ST_OUT;
               end
               launched_in = 1'b1;
            end
         end
         ST_MISS: begin
            m_a = $signed({32'd0, step_ff});
            m_b = missed_ff;
            mul_start = launched_ff;
            if (!launched_ff && !mul_busy) begin
               ltime_in = ltime_ff + m_prod[31:0];
               err_in = req_ff.beacon_time - (ltime_ff + m_prod[31:0]);
               rsp_in.local_estimate = ltime_ff + m_prod[31:0];
               rsp_in.timing_error = req_ff.beacon_time - (ltime_ff + m_prod[31:0]);
               rsp_in.frequency_estimate = foff_ff;
               state_in = ST_PHASE;
               launched_in = 1'b1;
            end
         end
         ST_PHASE: begin
            m_a = $signed({{32{err_ff[31]}}, err_ff});
            m_b = {16'd0, pgain_ff};
            mul_start = launched_ff;
            if (!launched_ff && !mul_busy) begin
               ltime_in = ltime_ff + perr;
               base_in = ltime_ff + perr;
               sidx_in = '0;
               state_in = ST_FGAIN;
               launched_in = 1'b1;
            end
         end
         ST_FGAIN: begin
            m_a = $signed({{18{err_ff[31]}}, err_ff, 14'd0});
            m_b = {16'd0, fgain_ff};
            mul_start = launched_ff;
            if (!launched_ff && !mul_busy) begin
               fg_in = m_prod;
               state_in = ST_DIV;
               launched_in = 1'b1;
            end
         end
         ST_DIV: begin
            div_start = launched_ff;
            if (!launched_ff && !div_busy) begin
               if (fnew > 64'sd2147483647) foff_in = 32'h7FFF_FFFF;
               else if (fnew < -64'sd2147483648) foff_in = 32'h8000_0000;
               else foff_in = fnew[31:0];
               state_in = ST_STEP2;
               launched_in = 1'b1;
            end
         end
         ST_SLOT: begin
            m_a = $signed({44'd0, slen_ff});
            m_b = {28'd0, sidx_ff};
            mul_start = launched_ff;
            if (!launched_ff && !mul_busy) begin
               if (32'(sidx_ff) < FRAME_SLOT_COUNT) begin
                  if (req_ff.slot_is_uplink && req_ff.slot_owner == node_ff) begin
                     rsp_in.transmit_grant = 1'b1;
                     rsp_in.transmit_time = base_ff + m_prod[31:0];
                  end
                  sidx_in = sidx_ff + 4'd1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         interval_ff <= 24'd10000; pgain_ff <= 16'd32768;
         fgain_ff <= 16'd8192; slen_ff <= 20'd1000; node_ff <= 16'd1;
         ltime_ff <= '0; foff_ff <= '0; prev_ff <= '0; base_ff <= '0;
         sidx_ff <= '0; rvalid_ff <= 1'b0; launched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ltime_ff <= ltime_in; foff_ff <= foff_in; prev_ff <= prev_in;
         base_ff <= base_in; sidx_ff <= sidx_in; rvalid_ff <= rvalid_in;
         launched_ff <= launched_in;
         if (csr_write) begin
            unique case (csr_idx_type'(csr_index))
               CSR_BEACON_INTERVAL: interval_ff <= csr_wdata;
               CSR_PHASE_GAIN:      pgain_ff <= csr_wdata[15:0];
               CSR_FREQUENCY_GAIN:  fgain_ff <= csr_wdata[15:0];
               CSR_SLOT_LENGTH:     slen_ff <= csr_wdata[19:0];
               CSR_OWN_NODE_ID:     node_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      req_ff <= req_in; missed_ff <= missed_in; err_ff <= err_in;
      step_ff <= step_in; rsp_ff <= rsp_in; fg_ff <= fg_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == ST_IDLE && !rvalid_ff) else $error("accept while busy");
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy)) else $error("mul and div both busy");
   a_slot_idx: assert property (@(posedge clock) disable iff (reset)
      32'(sidx_ff) <= FRAME_SLOT_COUNT) else $error("slot index overrun");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT) else $error("stray response");

endmodule

>>> hw/rtl/tbct_serial_mul.sv
// ----------------------------------------------------------------------------
// tbct_serial_mul: bit-serial signed multiplier
// Shift-add multiply of a signed 64-bit multiplicand by an unsigned 32-bit
// multiplier, one multiplier bit per cycle, product modulo 2^64.
// ----------------------------------------------------------------------------
module tbct_serial_mul
   import tbct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] mcand,
   input  logic [31:0]        mplier,
   output logic               busy,
   output logic signed [63:0] product
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] mc_ff, mc_in;
   logic [31:0] mp_ff, mp_in;
   logic [5:0]  cnt_ff, cnt_in;

   always_comb begin
      acc_in = acc_ff;
      mc_in  = mc_ff;
      mp_in  = mp_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = '0;
         mc_in  = mcand;
         mp_in  = mplier;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = {mc_ff[62:0], 1'b0};
         mp_in  = {1'b0, mp_ff[31:1]};
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign busy    = (cnt_ff != 6'd0);
   assign product = acc_ff;

endmodule

>>> hw/rtl/tbct_serial_div.sv
// ----------------------------------------------------------------------------
// tbct_serial_div: bit-serial signed divider
// Restoring division of a signed 64-bit dividend by an unsigned 24-bit
// divisor, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tbct_serial_div
   import tbct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [23:0]        divisor,
   output logic               busy,
   output logic signed [63:0] quotient
);

   logic [63:0] q_ff, q_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dv_ff, dv_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [24:0] trial;
   logic [25:0] diff;

   assign trial = {rem_ff[23:0], q_ff[63]};
   assign diff  = {1'b0, trial} - {2'b00, dv_ff};

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      dv_in  = dv_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (start) begin
         neg_in = dividend[63];
         q_in   = dividend[63] ? 64'(-dividend) : dividend;
         rem_in = '0;
         dv_in  = (divisor == 24'd0) ? 24'd1 : divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!diff[25]) begin
            rem_in = diff[24:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      neg_ff <= neg_in;
   end

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = neg_ff ? 64'(-q_ff) : q_ff;

endmodule

>>> bench/tb_tdma_beacon_clock_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tdma_beacon_clock_tracker: self-checking bench for the beacon tracker
// Drives beacon headers and slot entries under random idle and stall patterns.
// A local model of the timing loop predicts every report. Each report is
// checked field by field, and register settings are swept between phases.
// ----------------------------------------------------------------------------
module tb_tdma_beacon_clock_tracker;
   import tbct_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_write;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   tdma_beacon_clock_tracker dut (.*);

   // tracker model: registers and loop state
   logic [23:0]        cfg_interval;
   logic [15:0]        cfg_phase_gain;
   logic [15:0]        cfg_freq_gain;
   logic [19:0]        cfg_slot_length;
   logic [15:0]        cfg_node_id;
   logic [31:0]        trk_local_time;
   logic signed [31:0] trk_freq;
   logic [31:0]        trk_prev_number;
   logic [31:0]        trk_slot_base;
   logic [3:0]         trk_slot_index;

   rsp_type report_queue[$];
   int      idle_pct;
   int      stall_pct;
   int      mismatch_count;
   int      report_count;
   int      beacon_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #100000000;
      $display("simulation failed");
      $finish;
   end

   function automatic longint signed interval_step();
      longint signed p;
      p = longint'(cfg_interval) * (longint'(trk_freq) + 64'sd1073741824);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic rsp_type predict_report(req_type r);
      rsp_type            o;
      logic [31:0]        missed;
      longint signed      prod;
      logic signed [31:0] err;
      longint signed      delta;
      longint signed      fnew;
      logic [23:0]        div;
      o = '0;
      if (op_type'(r.op) == OP_BEACON) begin
         missed = (r.beacon_number > trk_prev_number) ?
                  r.beacon_number - trk_prev_number - 32'd1 : 32'd0;
         trk_prev_number = r.beacon_number;
         prod = longint'(missed) * interval_step();
         trk_local_time = trk_local_time + prod[31:0];
         err = r.beacon_time - trk_local_time;
         o.report_kind = 1'b0;
         o.local_estimate = trk_local_time;
         o.timing_error = err;
         o.frequency_estimate = trk_freq;
         prod = (longint'(cfg_phase_gain) * longint'(err) + 64'sd32768) >>> 16;
         trk_local_time = trk_local_time + prod[31:0];
         div = (cfg_interval == 0) ? 24'd1 : cfg_interval;
         delta = (longint'(cfg_freq_gain) * longint'(err) * 64'sd16384) / longint'(div);
         fnew = longint'(trk_freq) + delta;
         if (fnew > 64'sd2147483647) fnew = 64'sd2147483647;
         if (fnew < -64'sd2147483648) fnew = -64'sd2147483648;
         trk_freq = fnew[31:0];
         trk_slot_base = trk_local_time;
         trk_slot_index = 4'd0;
         prod = interval_step();
         trk_local_time = trk_local_time + prod[31:0];
      end else begin
         o.report_kind = 1'b1;
         if (trk_slot_index < FRAME_SLOT_COUNT) begin
            if (r.slot_is_uplink && r.slot_owner == cfg_node_id) begin
               o.transmit_grant = 1'b1;
               o.transmit_time = trk_slot_base + 32'(trk_slot_index) * 32'(cfg_slot_length);
            end
            trk_slot_index = trk_slot_index + 4'd1;
         end
      end
      return o;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_queue.size() == 0) begin
            $error("unexpected report transaction");
            mismatch_count++;
         end else begin
            e = report_queue.pop_front();
            report_count++;
            check_field("report_kind", 32'(e.report_kind), 32'(rsp_data.report_kind));
            check_field("local_estimate", e.local_estimate, rsp_data.local_estimate);
            check_field("timing_error", e.timing_error, rsp_data.timing_error);
            check_field("frequency_estimate", e.frequency_estimate,
                        rsp_data.frequency_estimate);
            check_field("transmit_grant", 32'(e.transmit_grant),
                        32'(rsp_data.transmit_grant));
            check_field("transmit_time", e.transmit_time, rsp_data.transmit_time);
         end
      end
   end

   // One transaction on the request channel; prediction at acceptance.
   task automatic send_item(req_type r);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      report_queue.push_back(predict_report(r));
      if (op_type'(r.op) == OP_BEACON) beacon_count++;
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CsrDataW-1:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_BEACON_INTERVAL: cfg_interval = v[23:0];
         CSR_PHASE_GAIN:      cfg_phase_gain = v[15:0];
         CSR_FREQUENCY_GAIN:  cfg_freq_gain = v[15:0];
         CSR_SLOT_LENGTH:     cfg_slot_length = v[19:0];
         CSR_OWN_NODE_ID:     cfg_node_id = v[15:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [23:0] bi, logic [15:0] pg, logic [15:0] fg,
                                logic [19:0] sl, logic [15:0] id);
      go_quiet();
      write_csr(CSR_BEACON_INTERVAL, bi);
      write_csr(CSR_PHASE_GAIN, 24'(pg));
      write_csr(CSR_FREQUENCY_GAIN, 24'(fg));
      write_csr(CSR_SLOT_LENGTH, 24'(sl));
      write_csr(CSR_OWN_NODE_ID, 24'(id));
   endtask

   function automatic req_type beacon_item(logic [31:0] t, logic [31:0] n);
      req_type r;
      r = '0;
      r.op = OP_BEACON;
      r.beacon_time = t;
      r.beacon_number = n;
      return r;
   endfunction

   function automatic req_type slot_item(logic [15:0] owner, logic ul);
      req_type r;
      r = '0;
      r.op = OP_SLOT;
      r.slot_owner = owner;
      r.slot_is_uplink = ul;
      return r;
   endfunction

   // Well-formed header: usually the next number, sometimes a small skip; time close to where the loop expects it.
   function automatic req_type tracked_beacon();
      logic [31:0]   n;
      logic [31:0]   missed;
      longint signed prod;
      int            span;
      n = trk_prev_number + (($urandom_range(9) < 8) ? 32'd1 : 32'($urandom_range(2, 4)));
      missed = n - trk_prev_number - 32'd1;
      prod = longint'(missed) * interval_step();
      span = (cfg_interval >> 3) + 1;
      return beacon_item(trk_local_time + prod[31:0] + 32'($urandom_range(2 * span)) -
                         32'(span), n);
   endfunction

   task automatic test_slots_before_beacon();
      send_item(slot_item(16'd1, 1'b1));
      send_item(slot_item(16'd1, 1'b0));
      send_item(slot_item(16'd2, 1'b1));
   endtask

   task automatic test_field_extremes();
      send_item(beacon_item(32'd0, 32'd0));               // repair, no advance
      send_item(beacon_item(32'hFFFF_FFFF, 32'd1));
      send_item(beacon_item(32'h8000_0000, 32'hFFFF_FFFF)); // huge gap
      send_item(beacon_item(32'h7FFF_FFFF, 32'd5));         // number going back
      send_item(slot_item(16'hFFFF, 1'b1));
      send_item(slot_item(16'd0, 1'b1));
      send_item(beacon_item(32'h1234_5678, 32'd6));
   endtask

   task automatic test_slot_overrun();
      send_item(beacon_item(trk_local_time, trk_prev_number + 32'd1));
      repeat (13) send_item(slot_item(cfg_node_id, 1'b1));
   endtask

   task automatic test_register_extremes();
      load_settings(24'd1, 16'hFFFF, 16'hFFFF, 20'd1, 16'd0);
      send_item(beacon_item(32'hFFFF_FFFF, 32'd100));
      send_item(slot_item(16'd0, 1'b1));
      send_item(beacon_item(32'h0, 32'd101));
      load_settings(24'hFF_FFFF, 16'd0, 16'd0, 20'hF_FFFF, 16'hFFFF);
      send_item(beacon_item(32'h8000_0000, 32'd102));
      repeat (3) send_item(slot_item(16'hFFFF, 1'b1));
      load_settings(24'd0, 16'd32768, 16'd8192, 20'd1000, 16'd1);  // zero interval
      send_item(beacon_item(32'h0000_1000, 32'd103));
   endtask

   task automatic run_random(int count);
      int k;
      int nslots;
      k = 0;
      while (k < count) begin
         if ($urandom_range(9) < 8) begin
            send_item(tracked_beacon());
            nslots = $urandom_range(0, 12);
            k += 1 + nslots;
            repeat (nslots) begin
               if ($urandom_range(1)) send_item(slot_item(cfg_node_id, $urandom_range(1)));
               else send_item(slot_item(16'($urandom), $urandom_range(1)));
            end
         end else begin
            if ($urandom_range(1)) send_item(beacon_item($urandom, $urandom));
            else send_item(slot_item(16'($urandom), $urandom_range(1)));
            k++;
         end
      end
   endtask

   task automatic test_random_phases();
      int p;
      for (p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         if (p == 4)
            load_settings(24'd10000, 16'd32768, 16'd8192, 20'd1000, 16'd1);
         else if (p > 0)
            load_settings(24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 20)),
                          16'($urandom), 16'($urandom >> $urandom_range(0, 15)),
                          20'($urandom_range(1, 20'hF_FFFF) >> $urandom_range(0, 16)),
                          16'($urandom));
         run_random(175);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_BEACON_INTERVAL;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      report_count = 0;
      beacon_count = 0;
      cfg_interval = 24'd10000;
      cfg_phase_gain = 16'd32768;
      cfg_freq_gain = 16'd8192;
      cfg_slot_length = 20'd1000;
      cfg_node_id = 16'd1;
      trk_local_time = '0;
      trk_freq = '0;
      trk_prev_number = '0;
      trk_slot_base = '0;
      trk_slot_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_slots_before_beacon();
      test_field_extremes();
      test_slot_overrun();
      test_register_extremes();
      go_quiet();   // sender holds off until every report is back
      test_random_phases();
      go_quiet();

      $display("Checked %0d reports (%0d beacon headers) over swept register settings,",
               report_count, beacon_count);
      $display("with sender idle and receiver stall phases.");
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/tbct_pkg.sv
hw/rtl/tbct_serial_mul.sv
hw/rtl/tbct_serial_div.sv
hw/rtl/tdma_beacon_clock_tracker.sv
bench/tb_tdma_beacon_clock_tracker.sv
